/* hdl/cp_pkg.sv */
// ----------------------------------------------------------------------------
// cp_pkg: shared types and constants of the CIGAR pileup counter
// Holds the operation record that passes from the parser to the engine,
// the command codes of the input channel and the character constants.
// ----------------------------------------------------------------------------
package cp_pkg;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_CIGAR = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OP_BEGIN  = 3'd0,
      OP_LOAD   = 3'd1,
      OP_MATCH  = 3'd2,
      OP_DELETE = 3'd3,
      OP_INSERT = 3'd4,
      OP_QUERY  = 3'd5
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [31:0] arg;
   } op_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } eng_status_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_M    = 8'h4D;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_I    = 8'h49;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_G    = 8'h47;
   localparam logic [7:0] CHAR_T    = 8'h54;

   localparam logic [2:0] CODE_A = 3'd0;
   localparam logic [2:0] CODE_C = 3'd1;
   localparam logic [2:0] CODE_G = 3'd2;
   localparam logic [2:0] CODE_T = 3'd3;
   localparam logic [2:0] CODE_N = 3'd4;

   localparam logic [11:0] RUN_MAX = 12'd4095;

endpackage

/* hdl/cp_ram.sv */
// ----------------------------------------------------------------------------
// cp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/cp_queue.sv */
// ----------------------------------------------------------------------------
// cp_queue: short operation queue between parser and engine
// A small circular buffer of operation records with an occupancy count.
// ----------------------------------------------------------------------------
module cp_queue
   import cp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  op_type             op_in,
   output logic               full,
   input  logic               pop,
   output op_type             op_out,
   output logic               empty,
   output logic [QPTR_BITS:0] count
);

   op_type                 entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= op_in;
      end
   end

   assign full   = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign op_out = entry_ff[rd_ptr_ff];
   assign count  = count_ff;

endmodule

/* hdl/cp_front.sv */
// ----------------------------------------------------------------------------
// cp_front: command parser
// Accepts input transfers, decodes bases, accumulates CIGAR run lengths and
// queues one operation record for each begin, base load, query and M, D or I.
// ----------------------------------------------------------------------------
module cp_front
   import cp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        q_full,
   output logic        q_push,
   output op_type      q_op
);

   logic [11:0] run_ff, run_in;
   logic [15:0] prod;
   logic        accept;
   logic        push_c;
   cmd_type     cmd;
   logic [31:0] rpos;
   logic [7:0]  sym;
   logic [9:0]  qidx;

   function automatic logic [2:0] base_code(input logic [7:0] s);
      logic [2:0] code;
      case (s)
         CHAR_A:  code = CODE_A;
         CHAR_C:  code = CODE_C;
         CHAR_G:  code = CODE_G;
         CHAR_T:  code = CODE_T;
         default: code = CODE_N;
      endcase
      return code;
   endfunction

   always_comb begin
      cmd    = cmd_type'(req_tdata[1:0]);
      rpos   = req_tdata[33:2];
      sym    = req_tdata[41:34];
      qidx   = req_tdata[51:42];
      accept = req_tvalid && !q_full;
      push_c = 1'b0;
      run_in = run_ff;
      prod   = 16'(run_ff) * 16'd10 + 16'(sym - CHAR_ZERO);
      q_op.kind = OP_BEGIN;
      q_op.arg  = rpos;
      case (cmd)
         CMD_BEGIN: begin
            push_c = 1'b1;
            run_in = '0;
         end
         CMD_LOAD: begin
            push_c    = 1'b1;
            q_op.kind = OP_LOAD;
            q_op.arg  = 32'(base_code(sym));
         end
         CMD_CIGAR: begin
            q_op.arg = 32'(run_ff);
            if (sym inside {[8'h30:8'h39]}) begin
               run_in = (prod > 16'(RUN_MAX)) ? RUN_MAX : prod[11:0];
            end else if (sym inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
               run_in = '0;
               if (sym == CHAR_M) begin
                  push_c    = 1'b1;
                  q_op.kind = OP_MATCH;
               end else if (sym == CHAR_D) begin
                  push_c    = 1'b1;
                  q_op.kind = OP_DELETE;
               end else if (sym == CHAR_I) begin
                  push_c    = 1'b1;
                  q_op.kind = OP_INSERT;
               end
            end
         end
         CMD_QUERY: begin
            push_c    = 1'b1;
            q_op.kind = OP_QUERY;
            q_op.arg  = 32'(qidx);
         end
         default: begin
            push_c = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (accept) begin
         run_ff <= run_in;
      end
   end

   assign req_tready = !q_full;
   assign q_push     = accept && push_c;

endmodule

/* hdl/cp_engine.sv */
// ----------------------------------------------------------------------------
// cp_engine: pileup engine
// Executes queued operations against the counter memory with one
// read-modify-write per covered position, and answers queries.
// ----------------------------------------------------------------------------
module cp_engine
   import cp_pkg::*;
#(
   parameter int WINDOW     = 1024,
   parameter int READ_MAX   = 128,
   parameter int COUNT_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [31:0]    window_start,
   input  logic [10:0]    window_length,
   input  logic           q_empty,
   input  op_type         q_op,
   output logic           q_pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [135:0]   rsp_tdata,
   output eng_status_type status
);

   localparam int AW  = $clog2(WINDOW);
   localparam int BAW = $clog2(READ_MAX);
   localparam int LW  = $clog2(READ_MAX + 1);
   localparam int CW  = 8 * COUNT_BITS;
   localparam logic signed [33:0] OFF_MAX = {1'b0, {33{1'b1}}};

   typedef logic [7:0][COUNT_BITS-1:0] cnt_vec_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_QUERY = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic signed [33:0] offset_ff, offset_in;
   logic [LW-1:0]      loaded_ff, loaded_in;
   logic [LW-1:0]      cursor_ff, cursor_in;
   logic [11:0]        remain_ff, remain_in;
   op_kind_type        kind_ff, kind_in;
   logic               hit_ff, hit_in;
   logic               base_ok_ff, base_ok_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               qok_ff, qok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [135:0]       rsp_data_ff, rsp_data_in;

   logic [32:0]        eff_len;
   logic               in_window;
   logic [LW+12:0]     cur_sum;
   logic signed [33:0] offset_step;

   logic               cnt_wr_en;
   logic [AW-1:0]      cnt_wr_addr;
   cnt_vec_type        cnt_wr_data;
   logic [AW-1:0]      cnt_rd_addr;
   cnt_vec_type        cnt_rd_data;
   logic               base_wr_en;
   logic [2:0]         base_rd_data;
   logic [2:0]         code;
   cnt_vec_type        qv;
   logic [COUNT_BITS-1:0] best;
   logic [1:0]         top;

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   cp_ram #(.WIDTH(CW), .DEPTH(WINDOW)) u_counters (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   cp_ram #(.WIDTH(3), .DEPTH(READ_MAX)) u_bases (
      .clock   (clock),
      .wr_en   (base_wr_en),
      .wr_addr (loaded_ff[BAW-1:0]),
      .wr_data (q_op.arg[2:0]),
      .rd_addr (cursor_ff[BAW-1:0]),
      .rd_data (base_rd_data)
   );

   always_comb begin
      eff_len = (33'(window_length) > 33'(WINDOW)) ? 33'(WINDOW) : 33'(window_length);
      in_window = !offset_ff[33] && (offset_ff[32:0] < eff_len);
      cur_sum = (LW+13)'(cursor_ff) + (LW+13)'(q_op.arg[11:0]);
      offset_step = (offset_ff == OFF_MAX) ? offset_ff : offset_ff + 34'sd1;

      state_in     = state_ff;
      clr_in       = clr_ff;
      offset_in    = offset_ff;
      loaded_in    = loaded_ff;
      cursor_in    = cursor_ff;
      remain_in    = remain_ff;
      kind_in      = kind_ff;
      hit_in       = hit_ff;
      base_ok_in   = base_ok_ff;
      addr_in      = addr_ff;
      qok_in       = qok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      base_wr_en   = 1'b0;
      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = addr_ff;
      cnt_wr_data  = cnt_rd_data;
      cnt_rd_addr  = offset_ff[AW-1:0];

      code = CODE_N;
      if (base_ok_ff && (base_rd_data < CODE_N)) begin
         code = base_rd_data;
      end

      qv = qok_ff ? cnt_rd_data : '0;
      best = qv[3];
      top  = 2'd0;
      for (int j = 1; j < 4; j++) begin
         if (qv[3+j] > best) begin
            best = qv[3+j];
            top  = 2'(j);
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
            cnt_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == AW'(WINDOW - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_rd_addr = q_op.arg[AW-1:0];
            if (!q_empty && ((q_op.kind != OP_QUERY) || !rsp_valid_ff)) begin
               q_pop   = 1'b1;
               kind_in = q_op.kind;
               case (q_op.kind)
                  OP_BEGIN: begin
                     offset_in = $signed({2'b00, q_op.arg}) - $signed({2'b00, window_start});
                     loaded_in = '0;
                     cursor_in = '0;
                  end
                  OP_LOAD: begin
                     if (loaded_ff < LW'(READ_MAX)) begin
                        base_wr_en = 1'b1;
                        loaded_in  = loaded_ff + 1'b1;
                     end
                  end
                  OP_MATCH, OP_DELETE: begin
                     remain_in = q_op.arg[11:0];
                     if (q_op.arg[11:0] != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  OP_INSERT: begin
                     remain_in = 12'd1;
                     cursor_in = (cur_sum > (LW+13)'(READ_MAX)) ? LW'(READ_MAX)
                                                               : cur_sum[LW-1:0];
                     state_in  = ST_READ;
                  end
                  OP_QUERY: begin
                     qok_in   = (q_op.arg < 32'(WINDOW));
                     state_in = ST_QUERY;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            hit_in     = in_window;
            addr_in    = offset_ff[AW-1:0];
            base_ok_in = (cursor_ff < loaded_ff);
            remain_in  = remain_ff - 1'b1;
            if (kind_ff != OP_INSERT) begin
               offset_in = offset_step;
            end
            if ((kind_ff == OP_MATCH) && (cursor_ff < LW'(READ_MAX))) begin
               cursor_in = cursor_ff + 1'b1;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cnt_wr_en = hit_ff;
            case (kind_ff)
               OP_MATCH: begin
                  cnt_wr_data[0]        = bump(cnt_rd_data[0]);
                  cnt_wr_data[3 + code] = bump(cnt_rd_data[3 + code]);
               end
               OP_DELETE: cnt_wr_data[2] = bump(cnt_rd_data[2]);
               OP_INSERT: cnt_wr_data[1] = bump(cnt_rd_data[1]);
               default:   cnt_wr_en = 1'b0;
            endcase
            state_in = (remain_ff == '0) ? ST_IDLE : ST_READ;
         end
         ST_QUERY: begin
            // The counter read issued on pop is available in this cycle.
            for (int j = 0; j < 8; j++) begin
               rsp_data_in[16*j +: 16] = 16'(qv[j]);
            end
            rsp_data_in[129:128] = top;
            rsp_data_in[135:130] = '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         offset_ff    <= '0;
         loaded_ff    <= '0;
         cursor_ff    <= '0;
         remain_ff    <= '0;
         kind_ff      <= OP_BEGIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         offset_ff    <= offset_in;
         loaded_ff    <= loaded_in;
         cursor_ff    <= cursor_in;
         remain_ff    <= remain_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff      <= hit_in;
      base_ok_ff  <= base_ok_in;
      addr_ff     <= addr_in;
      qok_ff      <= qok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.idle     = (state_ff == ST_IDLE);

endmodule

/* hdl/cigar_pileup_counter.sv */
// ----------------------------------------------------------------------------
// cigar_pileup_counter: per-position pileup from aligned reads
// Parser, operation queue and pileup engine with the configuration registers.
// ----------------------------------------------------------------------------
// The parser takes one transfer per cycle while its four-entry queue has
// room. The engine pops each operation in its idle state, which is all
// that a begin or a base load needs; an M or D run then goes through a read
// and a write state for every covered position and an I through them once,
// because every covered position is a read-modify-write of the counter
// memory, and a query goes through a query state to form its answer and is
// not taken while an earlier answer still waits on the response side. After
// reset the engine clears the counter memory before it executes anything;
// transfers are queued meanwhile and configuration writes are taken as ever.
module cigar_pileup_counter
   import cp_pkg::*;
#(
   parameter int WINDOW     = 1024,
   parameter int READ_MAX   = 128,
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[1:0], read_position[33:2], symbol[41:34], query_index[51:42]
   input  logic [55:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // match_count, insert_count, delete_count, count_a, count_c, count_g,
   // count_t, count_n (16 bits each from bit 0), top_base[129:128]
   output logic [135:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data
);

   localparam logic CSR_WINDOW_START  = 1'b0;
   localparam logic CSR_WINDOW_LENGTH = 1'b1;

   logic [31:0]        window_start_ff;
   logic [10:0]        window_length_ff;
   logic               q_push, q_pop, q_full, q_empty;
   op_type             q_in, q_out;
   logic [QPTR_BITS:0] q_count;
   eng_status_type     status;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff  <= '0;
         window_length_ff <= 11'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_START:  window_start_ff  <= csr_data;
            CSR_WINDOW_LENGTH: window_length_ff <= csr_data[10:0];
            default:           window_start_ff  <= window_start_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   cp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (q_in)
   );

   cp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .op_in  (q_in),
      .full   (q_full),
      .pop    (q_pop),
      .op_out (q_out),
      .empty  (q_empty),
      .count  (q_count)
   );

   cp_engine #(
      .WINDOW     (WINDOW),
      .READ_MAX   (READ_MAX),
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .window_start  (window_start_ff),
      .window_length (window_length_ff),
      .q_empty       (q_empty),
      .q_op          (q_out),
      .q_pop         (q_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .status        (status)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("operation queue count exceeds its depth");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> status.idle && !q_empty)
      else $error("operation taken while engine busy or queue empty");

   a_no_reply_in_clear: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !rsp_tvalid && !q_pop)
      else $error("engine active during the clearing pass");

endmodule
